@@ hw/rtl/ratb_pkg.sv @@
`default_nettype none
package ratb_pkg;
  typedef struct packed {
    logic [4:0] sin;
    logic [4:0] cos;
  } pair_t;
endpackage
`default_nettype wire

@@ hw/rtl/rational_angle_table_builder.sv @@
`default_nettype none
// Builds a table of rational points (s, c) near the quarter circle of radius d, sorted by
// angle, one output beat per entry with gcd(s, c) and tlast on the final entry. One
// request runs through a sequencer around a single 5x5 multiply-compare unit: roots by
// incremental search, insertion by a scan and shift of the table memory, and gcd by
// subtraction. tready is low from the accepted request until the last beat is taken,
// including any output stalls. Denominators above DEN_MAX saturate to DEN_MAX.
module rational_angle_table_builder
  import ratb_pkg::*;
#(
  parameter int DEN_MAX     = 31,
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [4:0] denominator
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [15:0]     m_axis_tdata,   // [4:0] sine, [9:5] cosine, [14:10] gcd
  output logic            m_axis_tlast
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROOT  = 4'd1;
  localparam logic [3:0] S_RFIX  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_SCMP  = 4'd4;
  localparam logic [3:0] S_SHRD  = 4'd5;
  localparam logic [3:0] S_SHWR  = 4'd6;
  localparam logic [3:0] S_INS   = 4'd7;
  localparam logic [3:0] S_ORD   = 4'd8;
  localparam logic [3:0] S_OGCD  = 4'd9;
  localparam logic [3:0] S_OWAIT = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]    st_q, st_d;
  logic [4:0]    den_q, den_d, i_q, i_d, r_q, r_d;
  logic [9:0]    n_q, n_d, d2_q, d2_d;
  logic          sw_q, sw_d;
  logic [CW-1:0] cnt_q, cnt_d, pos_q, pos_d, k_q, k_d;
  pair_t         mem [TABLE_DEPTH];
  pair_t         rd_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  pair_t         wdata;
  logic [4:0]    gcd_q, gcd_d;
  logic          last_q, last_d;
  logic          gstart, gdone;
  logic [4:0]    gres;

  // shared multiply unit: a * b, 10 bits
  logic [4:0] mul_a, mul_b;
  logic [9:0] prod, lhs_q, lhs_d;
  assign prod = 10'(mul_a) * 10'(mul_b);

  pair_t cur;
  assign cur.sin = sw_q ? r_q : i_q;
  assign cur.cos = sw_q ? i_q : r_q;

  logic [4:0] din;
  assign din = (s_axis_tdata[4:0] > 5'(DEN_MAX)) ? 5'(DEN_MAX) : s_axis_tdata[4:0];

  ratb_gcd u_gcd (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(gstart),
    .a_i(rd_q.sin), .b_i(rd_q.cos), .done_o(gdone), .gcd_o(gres)
  );

  always_comb begin
    st_d = st_q; den_d = den_q; i_d = i_q; r_d = r_q; n_d = n_q; sw_d = sw_q;
    cnt_d = cnt_q; pos_d = pos_q; k_d = k_q; gcd_d = gcd_q; last_d = last_q;
    lhs_d = lhs_q; d2_d = d2_q;
    raddr = pos_q[AW-1:0]; we = 1'b0; waddr = pos_q[AW-1:0]; wdata = cur;
    mul_a = r_q; mul_b = r_q; gstart = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        mul_a = din; mul_b = din;
        if (s_axis_tvalid) begin
          den_d = din; i_d = 5'd0; cnt_d = '0;
          d2_d = prod;
          n_d = prod; // seeded for i = 0
          r_d = 5'd0; st_d = S_ROOT;
        end
      end
      // floor root: grow r while (r+1)^2 <= n
      S_ROOT: begin
        mul_a = r_q + 5'd1; mul_b = r_q + 5'd1;
        if ({1'b0, prod} <= {1'b0, n_q} && r_q != 5'd31) r_d = r_q + 5'd1;
        else st_d = S_RFIX;
      end
      S_RFIX: begin
        mul_a = r_q; mul_b = r_q;
        if (n_q - prod > 10'(r_q)) r_d = r_q + 5'd1;
        sw_d = 1'b0; pos_d = '0; st_d = S_SCAN;
      end
      // read entry at pos
      S_SCAN: begin
        raddr = pos_q[AW-1:0];
        if (pos_q == cnt_q) st_d = S_INS;
        else st_d = S_SCMP;
      end
      S_SCMP: begin
        mul_a = rd_q.sin; mul_b = cur.cos;
        lhs_d = prod;
        st_d = S_SHRD; // second half of the compare
      end
      S_SHRD: begin
        mul_a = cur.sin; mul_b = rd_q.cos;
        if (lhs_q == prod) begin
          st_d = S_INS; pos_d = '1; // drop marker
        end else if (lhs_q > prod) begin
          k_d = cnt_q; st_d = S_SHWR;
          raddr = '0;
        end else begin
          pos_d = pos_q + 1'b1; st_d = S_SCAN;
        end
        if (lhs_q > prod && cnt_q >= CW'(TABLE_DEPTH)) begin
          st_d = S_INS; pos_d = '1;
        end
      end
      // shift entries up: read k-1, then write k
      S_SHWR: begin
        if (k_q == pos_q) begin
          st_d = S_INS;
        end else begin
          raddr = AW'(k_q - 1'b1);
          st_d = S_ORD;
        end
      end
      S_ORD: begin
        we = 1'b1; waddr = k_q[AW-1:0]; wdata = rd_q;
        k_d = k_q - 1'b1; st_d = S_SHWR;
      end
      S_INS: begin
        if (pos_q != '1 && cnt_q < CW'(TABLE_DEPTH)) begin
          we = 1'b1; waddr = pos_q[AW-1:0]; wdata = cur;
          cnt_d = cnt_q + 1'b1;
        end
        if (!sw_q) begin
          sw_d = 1'b1; pos_d = '0; st_d = S_SCAN;
        end else if (i_q == den_q) begin
          k_d = '0; st_d = S_OGCD; raddr = '0;
        end else begin
          i_d = i_q + 5'd1;
          mul_a = i_q + 5'd1; mul_b = i_q + 5'd1;
          n_d = d2_q - prod;
          r_d = 5'd0; st_d = S_ROOT;
        end
      end
      S_OGCD: begin
        raddr = k_q[AW-1:0];
        st_d = S_OWAIT;
      end
      S_OWAIT: begin
        raddr = k_q[AW-1:0];
        gstart = (lhs_q != 10'h3fe);
        lhs_d = 10'h3fe;
        if (gdone) begin
          gcd_d = gres; last_d = (k_q + 1'b1 == cnt_q); st_d = S_OUT;
        end
      end
      S_OUT: begin
        raddr = k_q[AW-1:0];
        if (m_axis_tready) begin
          lhs_d = '0;
          if (last_q) st_d = S_IDLE;
          else begin
            k_d = k_q + 1'b1; st_d = S_OGCD;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = (st_q == S_OUT);
  assign m_axis_tdata  = {1'b0, gcd_q, rd_q.cos, rd_q.sin};
  assign m_axis_tlast  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d; i_q <= i_d; r_q <= r_d; n_q <= n_d; sw_q <= sw_d; d2_q <= d2_d;
    pos_q <= pos_d; k_q <= k_d; gcd_q <= gcd_d; last_q <= last_d; lhs_q <= lhs_d;
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/ratb_gcd.sv @@
`default_nettype none
// Euclidean gcd by repeated subtraction, one subtract or swap per cycle.
module ratb_gcd
  import ratb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [4:0] a_i,
  input  wire logic [4:0] b_i,
  output logic            done_o,
  output logic [4:0]      gcd_o
);
  logic [4:0] a_q, a_d, b_q, b_d;
  logic       busy_q, busy_d;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      a_d = a_i;
      b_d = b_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q == 5'd0) begin
        done_o = 1'b1;
        busy_d = 1'b0;
      end else if (a_q >= b_q) begin
        a_d = a_q - b_q;
      end else begin
        a_d = b_q;
        b_d = a_q;
      end
    end
  end
  assign gcd_o = a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end
endmodule
`default_nettype wire

@@ hw/rtl/ratb_checker.sv @@
`default_nettype none
module ratb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  // no new request taken while results are offered
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while output valid");
  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("beat dropped");
  // gcd never exceeds a nonzero numerator
  a_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4:0] != 5'd0 |-> m_axis_tdata[14:10] <= m_axis_tdata[4:0])
    else $error("gcd too large");
  // after the last beat the block returns to accept requests
  a_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("not idle after last");
endmodule

bind rational_angle_table_builder ratb_checker u_ratb_checker (.*);
`default_nettype wire
